FILE: hw/rtl/lavm_pkg.sv
package lavm_pkg;

	// Axis components are Q2.30
	localparam int AXIS_FRAC = 30;

	typedef logic signed [31:0] pos_t;
	typedef logic signed [32:0] diff_t;
	typedef logic signed [63:0] wide_t;

	// up register reset values, Q23.8 (+Z)
	localparam pos_t UP_RESET_X = 32'sd0;
	localparam pos_t UP_RESET_Y = 32'sd0;
	localparam pos_t UP_RESET_Z = 32'sd256;

	typedef enum logic [1:0] {
		CFG_UP_X = 2'd0,
		CFG_UP_Y = 2'd1,
		CFG_UP_Z = 2'd2
	} cfg_idx_t;

	// matrix row codes
	localparam logic [1:0] ROW_SIDE = 2'd0;
	localparam logic [1:0] ROW_UP   = 2'd1;
	localparam logic [1:0] ROW_FWD  = 2'd2;

	// queued work: eye point and eye minus target
	typedef struct packed {
		pos_t  eye_x;
		pos_t  eye_y;
		pos_t  eye_z;
		diff_t d_x;
		diff_t d_y;
		diff_t d_z;
	} item_t;

	typedef struct packed {
		logic [1:0] row_index;
		pos_t       axis_x;
		pos_t       axis_y;
		pos_t       axis_z;
		pos_t       translation;
		logic       last_row;
	} row_t;

	// handshake between the queue and the engine
	typedef struct packed {
		logic  valid;
		item_t item;
	} work_t;

endpackage

FILE: hw/rtl/lavm_fifo.sv
module lavm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (do_pop) begin
				rd_q <= ptr_next(rd_q);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("fifo count beyond depth");

endmodule

FILE: hw/rtl/lavm_front.sv
module lavm_front import lavm_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  pos_t  eye_x,
	input  pos_t  eye_y,
	input  pos_t  eye_z,
	input  pos_t  target_x,
	input  pos_t  target_y,
	input  pos_t  target_z,
	output work_t work,
	input  logic  take
);

	item_t in_item;
	item_t q_item;
	logic  q_empty;

	// forward direction before normalizing, 33 bits so it never wraps
	always_comb begin
		in_item.eye_x = eye_x;
		in_item.eye_y = eye_y;
		in_item.eye_z = eye_z;
		in_item.d_x   = diff_t'(eye_x) - diff_t'(target_x);
		in_item.d_y   = diff_t'(eye_y) - diff_t'(target_y);
		in_item.d_z   = diff_t'(eye_z) - diff_t'(target_z);
	end

	lavm_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (in_item),
		.full  (full),
		.pop   (take),
		.rdata (q_item),
		.empty (q_empty)
	);

	assign work.valid = !q_empty;
	assign work.item  = q_item;

endmodule

FILE: hw/rtl/lavm_norm.sv
module lavm_norm import lavm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  wide_t vin_x,
	input  wide_t vin_y,
	input  wide_t vin_z,
	output logic  done,
	output pos_t  axis_x,
	output pos_t  axis_y,
	output pos_t  axis_z
);

	typedef enum logic [2:0] {
		N_IDLE,
		N_SHIFT,
		N_SQ,
		N_SQRT,
		N_LOAD,
		N_DIV
	} nstate_t;

	localparam logic [4:0] DIV_LAST = 5'd30;
	localparam logic [4:0] SQ_LAST  = 5'd3;

	nstate_t     state_q;
	logic [1:0]  comp_q;
	logic [4:0]  cnt_q;
	logic        done_q;

	logic [63:0] m_q [3];
	logic [2:0]  neg_q;
	logic [61:0] prod_q;
	logic [63:0] sum_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [31:0] rem_q;
	logic [30:0] quo_q;
	pos_t        out_q [3];

	logic        hi;
	logic [63:0] sq_t;
	logic        sq_ge;
	logic [31:0] len_w;
	logic [63:0] sq_src;
	logic        div_in;
	logic [32:0] div_t;
	logic        div_ge;
	logic [32:0] div_r;
	logic [30:0] quo_n;
	pos_t        sres;

	function automatic logic [63:0] mag(input wide_t v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	// shift all three until the largest fits in 31 bits
	assign hi = |(m_q[0][63:31] | m_q[1][63:31] | m_q[2][63:31]);

	// restoring square root, two bits per step
	assign sq_t  = r_q + bit_q;
	assign sq_ge = (sum_q >= sq_t);
	assign len_w = (r_q[31:0] == '0) ? 32'd1 : r_q[31:0];

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    sq_src = m_q[0];
			2'd1:    sq_src = m_q[1];
			2'd2:    sq_src = m_q[2];
			default: sq_src = '0;
		endcase
	end

	// restoring divide of m << 30 by len, one quotient bit per step
	assign div_in = (cnt_q == '0) ? m_q[comp_q][0] : 1'b0;
	assign div_t  = {rem_q, div_in};
	assign div_ge = (div_t >= {1'b0, len_w});
	assign div_r  = div_ge ? (div_t - {1'b0, len_w}) : div_t;
	assign quo_n  = {quo_q[29:0], div_ge};
	assign sres   = neg_q[comp_q] ? -pos_t'({1'b0, quo_n}) : pos_t'({1'b0, quo_n});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			comp_q  <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				N_IDLE: begin
					if (start) begin
						state_q <= N_SHIFT;
					end
				end
				N_SHIFT: begin
					if (!hi) begin
						state_q <= N_SQ;
						cnt_q   <= '0;
					end
				end
				N_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SQ_LAST) begin
						state_q <= N_SQRT;
					end
				end
				N_SQRT: begin
					if (bit_q[0]) begin
						state_q <= N_LOAD;
						comp_q  <= '0;
					end
				end
				N_LOAD: begin
					state_q <= N_DIV;
					cnt_q   <= '0;
				end
				N_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						if (comp_q == 2'd2) begin
							state_q <= N_IDLE;
							done_q  <= 1'b1;
						end else begin
							comp_q  <= comp_q + 1'b1;
							state_q <= N_LOAD;
						end
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					m_q[0] <= mag(vin_x);
					m_q[1] <= mag(vin_y);
					m_q[2] <= mag(vin_z);
					neg_q  <= {vin_z[63], vin_y[63], vin_x[63]};
				end
			end
			N_SHIFT: begin
				if (hi) begin
					m_q[0] <= m_q[0] >> 1;
					m_q[1] <= m_q[1] >> 1;
					m_q[2] <= m_q[2] >> 1;
				end
			end
			N_SQ: begin
				if (cnt_q != SQ_LAST) begin
					prod_q <= sq_src[30:0] * sq_src[30:0];
				end
				sum_q <= (cnt_q == '0) ? '0 : sum_q + 64'(prod_q);
				r_q   <= '0;
				bit_q <= 64'(1) << 62;
			end
			N_SQRT: begin
				if (sq_ge) begin
					sum_q <= sum_q - sq_t;
					r_q   <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_LOAD: begin
				rem_q <= {2'b00, m_q[comp_q][30:1]};
				quo_q <= '0;
			end
			N_DIV: begin
				rem_q <= div_r[31:0];
				quo_q <= quo_n;
				if (cnt_q == DIV_LAST) begin
					out_q[comp_q] <= sres;
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign axis_x = out_q[0];
	assign axis_y = out_q[1];
	assign axis_z = out_q[2];

	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == N_DIV) |-> (rem_q < len_w))
		else $error("divide remainder not below divisor");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == N_IDLE && $past(state_q) == N_DIV))
		else $error("normalize done outside the last divide step");

endmodule

FILE: hw/rtl/lavm_back.sv
module lavm_back import lavm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  work_t work,
	output logic  take,
	input  pos_t  up_x,
	input  pos_t  up_y,
	input  pos_t  up_z,
	output logic  out_push,
	output row_t  out_row,
	input  logic  out_full
);

	typedef enum logic [2:0] {
		B_IDLE,
		B_NORM_F,
		B_CROSS,
		B_NORM_S,
		B_UPAX,
		B_DOT,
		B_EMIT
	} bstate_t;

	localparam logic [3:0] PAIR_OPS = 4'd6;
	localparam logic [3:0] DOT_OPS  = 4'd9;

	bstate_t     phase_q;
	logic [3:0]  k_q;
	logic        start_q;
	logic        pv_s1;
	logic [3:0]  pk_s1;
	logic [1:0]  er_q;

	pos_t        eye_q [3];
	diff_t       d_q [3];
	pos_t        f_q [3];
	pos_t        sd_q [3];
	pos_t        u_q [3];
	pos_t        tr_q [3];
	wide_t       c_q [3];
	wide_t       acc_q;
	wide_t       prod_s1;

	logic        norm_done;
	pos_t        n_x;
	pos_t        n_y;
	pos_t        n_z;
	wide_t       vin [3];

	logic [3:0]  n_ops;
	logic        prod_phase;
	logic        issue;
	logic        last;
	pos_t        va [3];
	pos_t        vb [3];
	pos_t        opa;
	pos_t        opb;
	logic [3:0]  ipos;
	logic [3:0]  dpos;
	logic [3:0]  ppos;
	wide_t       pair_res;
	wide_t       dot_res;
	logic signed [34:0] pair_rnd;
	pos_t        tr_sat;

	// operand indexes for a x b component pairs: {ia, ib}
	function automatic logic [3:0] pair_pos(input logic [3:0] k);
		case (k)
			4'd0:    return {2'd1, 2'd2};
			4'd1:    return {2'd2, 2'd1};
			4'd2:    return {2'd2, 2'd0};
			4'd3:    return {2'd0, 2'd2};
			4'd4:    return {2'd0, 2'd1};
			4'd5:    return {2'd1, 2'd0};
			default: return '0;
		endcase
	endfunction

	// dot products: {row, component}
	function automatic logic [3:0] dot_pos(input logic [3:0] k);
		case (k)
			4'd0:    return {ROW_SIDE, 2'd0};
			4'd1:    return {ROW_SIDE, 2'd1};
			4'd2:    return {ROW_SIDE, 2'd2};
			4'd3:    return {ROW_UP, 2'd0};
			4'd4:    return {ROW_UP, 2'd1};
			4'd5:    return {ROW_UP, 2'd2};
			4'd6:    return {ROW_FWD, 2'd0};
			4'd7:    return {ROW_FWD, 2'd1};
			4'd8:    return {ROW_FWD, 2'd2};
			default: return '0;
		endcase
	endfunction

	// >> 30 rounding half away from zero
	function automatic logic signed [34:0] rnd30(input wide_t v);
		logic [63:0] mg;
		logic [33:0] q;
		mg = v[63] ? 64'(-v) : 64'(v);
		q  = 34'((mg + (64'(1) << (AXIS_FRAC - 1))) >> AXIS_FRAC);
		return v[63] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

	function automatic pos_t axis_of(input logic [1:0] row, input logic [1:0] j,
	                                 input pos_t s0, input pos_t s1, input pos_t s2,
	                                 input pos_t u0, input pos_t u1, input pos_t u2,
	                                 input pos_t f0, input pos_t f1, input pos_t f2);
		pos_t a0;
		pos_t a1;
		pos_t a2;
		case (row)
			ROW_SIDE: begin a0 = s0; a1 = s1; a2 = s2; end
			ROW_UP:   begin a0 = u0; a1 = u1; a2 = u2; end
			default:  begin a0 = f0; a1 = f1; a2 = f2; end
		endcase
		case (j)
			2'd0:    return a0;
			2'd1:    return a1;
			default: return a2;
		endcase
	endfunction

	assign vin[0] = (phase_q == B_NORM_S) ? c_q[0] : 64'(d_q[0]);
	assign vin[1] = (phase_q == B_NORM_S) ? c_q[1] : 64'(d_q[1]);
	assign vin[2] = (phase_q == B_NORM_S) ? c_q[2] : 64'(d_q[2]);

	lavm_norm u_norm (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_q),
		.vin_x (vin[0]),
		.vin_y (vin[1]),
		.vin_z (vin[2]),
		.done  (norm_done),
		.axis_x(n_x),
		.axis_y(n_y),
		.axis_z(n_z)
	);

	assign prod_phase = (phase_q == B_CROSS) || (phase_q == B_UPAX) || (phase_q == B_DOT);
	assign n_ops      = (phase_q == B_DOT) ? DOT_OPS : PAIR_OPS;
	assign issue      = prod_phase && (k_q < n_ops);
	assign last       = pv_s1 && (pk_s1 == n_ops - 1'b1);

	always_comb begin
		if (phase_q == B_CROSS) begin
			va = '{up_x, up_y, up_z};
			vb = f_q;
		end else begin
			va = f_q;
			vb = sd_q;
		end
	end

	assign ipos = pair_pos(k_q);
	assign dpos = dot_pos(k_q);
	assign ppos = dot_pos(pk_s1);

	always_comb begin
		if (phase_q == B_DOT) begin
			opa = axis_of(dpos[3:2], dpos[1:0], sd_q[0], sd_q[1], sd_q[2],
			              u_q[0], u_q[1], u_q[2], f_q[0], f_q[1], f_q[2]);
			opb = eye_q[dpos[1:0]];
		end else begin
			opa = va[ipos[3:2]];
			opb = vb[ipos[1:0]];
		end
	end

	assign pair_res = acc_q - prod_s1;
	assign dot_res  = acc_q + prod_s1;
	assign pair_rnd = rnd30(pair_res);

	// translation: negate the rounded dot, clamp to 32 bits
	always_comb begin
		logic signed [35:0] nt;
		nt = -36'(rnd30(dot_res));
		if (nt > 36'sd2147483647) begin
			tr_sat = 32'sh7FFFFFFF;
		end else if (nt < -36'sd2147483648) begin
			tr_sat = 32'sh80000000;
		end else begin
			tr_sat = nt[31:0];
		end
	end

	assign take     = (phase_q == B_IDLE) && work.valid;
	assign out_push = (phase_q == B_EMIT) && !out_full;

	always_comb begin
		out_row.row_index   = er_q;
		out_row.axis_x      = axis_of(er_q, 2'd0, sd_q[0], sd_q[1], sd_q[2],
		                              u_q[0], u_q[1], u_q[2], f_q[0], f_q[1], f_q[2]);
		out_row.axis_y      = axis_of(er_q, 2'd1, sd_q[0], sd_q[1], sd_q[2],
		                              u_q[0], u_q[1], u_q[2], f_q[0], f_q[1], f_q[2]);
		out_row.axis_z      = axis_of(er_q, 2'd2, sd_q[0], sd_q[1], sd_q[2],
		                              u_q[0], u_q[1], u_q[2], f_q[0], f_q[1], f_q[2]);
		out_row.translation = tr_q[er_q];
		out_row.last_row    = (er_q == ROW_FWD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= B_IDLE;
			k_q     <= '0;
			start_q <= 1'b0;
			pv_s1   <= 1'b0;
			pk_s1   <= '0;
			er_q    <= '0;
		end else begin
			start_q <= 1'b0;
			pv_s1   <= issue;
			pk_s1   <= k_q;
			if (issue) begin
				k_q <= k_q + 1'b1;
			end
			unique case (phase_q)
				B_IDLE: begin
					if (work.valid) begin
						phase_q <= B_NORM_F;
						start_q <= 1'b1;
					end
				end
				B_NORM_F: begin
					if (norm_done) begin
						phase_q <= B_CROSS;
						k_q     <= '0;
					end
				end
				B_CROSS: begin
					if (last) begin
						phase_q <= B_NORM_S;
						start_q <= 1'b1;
					end
				end
				B_NORM_S: begin
					if (norm_done) begin
						phase_q <= B_UPAX;
						k_q     <= '0;
					end
				end
				B_UPAX: begin
					if (last) begin
						phase_q <= B_DOT;
						k_q     <= '0;
					end
				end
				B_DOT: begin
					if (last) begin
						phase_q <= B_EMIT;
						er_q    <= ROW_SIDE;
					end
				end
				B_EMIT: begin
					if (!out_full) begin
						er_q <= er_q + 1'b1;
						if (er_q == ROW_FWD) begin
							phase_q <= B_IDLE;
						end
					end
				end
				default: phase_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			eye_q <= '{work.item.eye_x, work.item.eye_y, work.item.eye_z};
			d_q   <= '{work.item.d_x, work.item.d_y, work.item.d_z};
		end
		if (norm_done && phase_q == B_NORM_F) begin
			f_q <= '{n_x, n_y, n_z};
		end
		if (norm_done && phase_q == B_NORM_S) begin
			sd_q <= '{n_x, n_y, n_z};
		end
		prod_s1 <= opa * opb;
		if (pv_s1) begin
			case (phase_q)
				B_CROSS: begin
					if (!pk_s1[0]) begin
						acc_q <= prod_s1;
					end else begin
						c_q[pk_s1[2:1]] <= pair_res;
					end
				end
				B_UPAX: begin
					if (!pk_s1[0]) begin
						acc_q <= prod_s1;
					end else begin
						u_q[pk_s1[2:1]] <= pair_rnd[31:0];
					end
				end
				B_DOT: begin
					case (ppos[1:0])
						2'd0:    acc_q <= prod_s1;
						2'd1:    acc_q <= dot_res;
						default: tr_q[ppos[3:2]] <= tr_sat;
					endcase
				end
				default: ;
			endcase
		end
	end

	a_start_phase: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> (phase_q == B_NORM_F || phase_q == B_NORM_S))
		else $error("normalize started outside a normalize phase");

	a_prod_phase: assert property (@(posedge clk) disable iff (!arst_n)
		pv_s1 |-> (phase_q == B_CROSS || phase_q == B_UPAX || phase_q == B_DOT))
		else $error("product in flight outside a multiply phase");

endmodule

FILE: hw/rtl/look_at_view_matrix_core.sv
// Channel   Handshake             Payload
// --------  --------------------  ---------------------------------------------
// input     push / full           eye_x/y/z, target_x/y/z  (Q23.8)
// result    pop / empty           row_index, axis_x/y/z (Q2.30), translation,
//                                 last_row; three words per input word
// config    cfg_valid / cfg_ready cfg_index, cfg_data (up_x/y/z, Q23.8)
//
// An input word's time in the engine is set mostly by the shared normalize
// unit: a shift search, a sum of squares, a 32-step square root and three 31-step
// divides, run once for forward and once for side.
// Input words queue up while the engine runs; rows wait in the result queue.
// Reset is asynchronous, active low; up resets to +Z (0, 0, 256).
// A stall on pop holds the engine only at row emit time.
module look_at_view_matrix_core import lavm_pkg::*; #(
	parameter int IN_DEPTH  = 2,
	parameter int OUT_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// input word
	input  logic       push,
	output logic       full,
	input  pos_t       eye_x,
	input  pos_t       eye_y,
	input  pos_t       eye_z,
	input  pos_t       target_x,
	input  pos_t       target_y,
	input  pos_t       target_z,
	// result word
	output logic       empty,
	input  logic       pop,
	output logic [1:0] row_index,
	output pos_t       axis_x,
	output pos_t       axis_y,
	output pos_t       axis_z,
	output pos_t       translation,
	output logic       last_row,
	// config write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  pos_t       cfg_data
);

	pos_t  up_x_q;
	pos_t  up_y_q;
	pos_t  up_z_q;
	work_t work;
	logic  take;
	logic  row_push;
	row_t  row_in;
	row_t  row_out;
	logic  row_full;

	// config writes are always taken; an index past up_z is dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_x_q <= UP_RESET_X;
			up_y_q <= UP_RESET_Y;
			up_z_q <= UP_RESET_Z;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_UP_X: up_x_q <= cfg_data;
				CFG_UP_Y: up_y_q <= cfg_data;
				CFG_UP_Z: up_z_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	// front: forms eye - target and queues the word
	lavm_front #(
		.DEPTH(IN_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.eye_x   (eye_x),
		.eye_y   (eye_y),
		.eye_z   (eye_z),
		.target_x(target_x),
		.target_y(target_y),
		.target_z(target_z),
		.work    (work),
		.take    (take)
	);

	// back: normalize, cross products, dots, then emit three rows
	lavm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.work    (work),
		.take    (take),
		.up_x    (up_x_q),
		.up_y    (up_y_q),
		.up_z    (up_z_q),
		.out_push(row_push),
		.out_row (row_in),
		.out_full(row_full)
	);

	// result queue decouples the engine from pop stalls
	lavm_fifo #(
		.WIDTH($bits(row_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (row_push),
		.wdata (row_in),
		.full  (row_full),
		.pop   (pop),
		.rdata (row_out),
		.empty (empty)
	);

	assign row_index   = row_out.row_index;
	assign axis_x      = row_out.axis_x;
	assign axis_y      = row_out.axis_y;
	assign axis_z      = row_out.axis_z;
	assign translation = row_out.translation;
	assign last_row    = row_out.last_row;

endmodule
